// ===== hw/rtl/q2e_pkg.sv =====
// shared types, constants and functions for the quaternion to euler angle pipeline
// no dependencies

package q2e_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FIELD_W      = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 31;
    localparam int PROD_W       = 32;
    localparam int SUM_W        = 34;
    localparam int CW           = 36;
    localparam int N_W          = 61;
    localparam int RES_W        = 62;
    localparam int ROOT_W       = 31;

    localparam int ANG_SHIFT = 32 - ANGLE_BITS;
    localparam logic [32:0] ANG_HALF = (33'd1 << ANG_SHIFT) >> 1;
    localparam logic [32:0] ANG_MASK = (33'd1 << ANGLE_BITS) - 33'd1;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_POS  = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG  = 32'hC000_0000;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [CW-1:0]      t_cw;

    localparam t_sum ONE_Q30 = t_sum'(64'sd1073741824);

    typedef struct packed {
        logic valid;
        logic clamp;
        t_sum sp;
        t_sum sy;
        t_sum cy;
        t_sum sr;
        t_sum cr;
    } t_side;

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_pflag;

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    function automatic logic [FIELD_W-1:0] to_angle(input logic [31:0] z);
        logic [32:0] s;
        logic [32:0] r;
        s = {1'b0, z} + ANG_HALF;
        r = (s >> ANG_SHIFT) & ANG_MASK;
        return r[FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/q2e_front.sv =====
// front end: products, sums of products, pitch clamp test and radicand for the root
// depends on q2e_pkg

module q2e_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  q2e_pkg::t_field           i_w,
    input  q2e_pkg::t_field           i_x,
    input  q2e_pkg::t_field           i_y,
    input  q2e_pkg::t_field           i_z,
    output q2e_pkg::t_side            o_side,
    output logic [q2e_pkg::N_W-1:0]   o_n
);

    logic            r_v1;
    q2e_pkg::t_prod  r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    q2e_pkg::t_side  r_side2, n_side2;
    q2e_pkg::t_side  r_side3, n_side3;
    q2e_pkg::t_side  r_side4;
    logic signed [2*q2e_pkg::ROOT_W-1:0] r_s2;
    logic [q2e_pkg::N_W-1:0] r_n;

    always_ff @(posedge i_clk) begin
        r_wx <= i_w * i_x;
        r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_wy <= i_w * i_y;
        r_zx <= i_z * i_x;
        r_wz <= i_w * i_z;
        r_xy <= i_x * i_y;
        r_zz <= i_z * i_z;
    end

    always_comb begin
        n_side2       = '0;
        n_side2.valid = r_v1;
        n_side2.sr    = (q2e_pkg::t_sum'(r_wx) + q2e_pkg::t_sum'(r_yz)) <<< 1;
        n_side2.cr    = q2e_pkg::ONE_Q30
                        - ((q2e_pkg::t_sum'(r_xx) + q2e_pkg::t_sum'(r_yy)) <<< 1);
        n_side2.sp    = (q2e_pkg::t_sum'(r_wy) - q2e_pkg::t_sum'(r_zx)) <<< 1;
        n_side2.sy    = (q2e_pkg::t_sum'(r_wz) + q2e_pkg::t_sum'(r_xy)) <<< 1;
        n_side2.cy    = q2e_pkg::ONE_Q30
                        - ((q2e_pkg::t_sum'(r_yy) + q2e_pkg::t_sum'(r_zz)) <<< 1);
    end

    always_comb begin
        n_side3       = r_side2;
        n_side3.clamp = (r_side2.sp >= q2e_pkg::ONE_Q30) || (r_side2.sp <= -q2e_pkg::ONE_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_side2.valid <= 1'b0;
            r_side3.valid <= 1'b0;
            r_side4.valid <= 1'b0;
        end else begin
            r_v1          <= i_valid;
            r_side2.valid <= n_side2.valid;
            r_side3.valid <= n_side3.valid;
            r_side4.valid <= r_side3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2.clamp <= n_side2.clamp;
        r_side2.sp    <= n_side2.sp;
        r_side2.sy    <= n_side2.sy;
        r_side2.cy    <= n_side2.cy;
        r_side2.sr    <= n_side2.sr;
        r_side2.cr    <= n_side2.cr;
        r_side3.clamp <= n_side3.clamp;
        r_side3.sp    <= n_side3.sp;
        r_side3.sy    <= n_side3.sy;
        r_side3.cy    <= n_side3.cy;
        r_side3.sr    <= n_side3.sr;
        r_side3.cr    <= n_side3.cr;
        r_s2          <= $signed(r_side2.sp[q2e_pkg::ROOT_W-1:0])
                         * $signed(r_side2.sp[q2e_pkg::ROOT_W-1:0]);
        r_side4.clamp <= r_side3.clamp;
        r_side4.sp    <= r_side3.sp;
        r_side4.sy    <= r_side3.sy;
        r_side4.cy    <= r_side3.cy;
        r_side4.sr    <= r_side3.sr;
        r_side4.cr    <= r_side3.cr;
        r_n           <= (q2e_pkg::N_W'(1) << (q2e_pkg::N_W - 1)) - r_s2[q2e_pkg::N_W-1:0];
    end

    assign o_side = r_side4;
    assign o_n    = r_n;

endmodule

// ===== hw/rtl/q2e_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on q2e_pkg

module q2e_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [q2e_pkg::N_W-1:0]      i_n,
    output logic                         o_valid,
    output logic [q2e_pkg::ROOT_W-1:0]   o_root
);

    localparam int STEPS = q2e_pkg::SQRT_STEPS;
    localparam int N_W   = q2e_pkg::N_W;
    localparam int RES_W = q2e_pkg::RES_W;

    logic             r_v   [0:STEPS-1];
    logic [N_W-1:0]   r_n   [0:STEPS-1];
    logic [RES_W-1:0] r_res [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (STEPS - 1 - k));
        logic             src_v;
        logic [N_W-1:0]   src_n;
        logic [RES_W-1:0] src_res;
        logic [RES_W-1:0] trial;

        if (k == 0) begin : g_first
            assign src_v   = i_valid;
            assign src_n   = i_n;
            assign src_res = '0;
        end else begin : g_next
            assign src_v   = r_v[k-1];
            assign src_n   = r_n[k-1];
            assign src_res = r_res[k-1];
        end

        assign trial = src_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if ({1'b0, src_n} >= trial) begin
                r_n[k]   <= src_n - trial[N_W-1:0];
                r_res[k] <= (src_res >> 1) + BIT;
            end else begin
                r_n[k]   <= src_n;
                r_res[k] <= src_res >> 1;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_res[STEPS-1][q2e_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/q2e_cordic.sv =====
// pipelined vectoring cordic giving atan2(y, x) as a 32-bit binary angle
// depends on q2e_pkg

module q2e_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  q2e_pkg::t_cw     i_y,
    input  q2e_pkg::t_cw     i_x,
    output logic             o_valid,
    output logic [31:0]      o_angle
);

    localparam int STEPS = q2e_pkg::CORDIC_STEPS;

    logic          r_pv;
    logic          r_phold;
    q2e_pkg::t_cw  r_px, r_py;
    logic [31:0]   r_pz;

    logic          r_v    [0:STEPS-1];
    logic          r_hold [0:STEPS-1];
    q2e_pkg::t_cw  r_x    [0:STEPS-1];
    q2e_pkg::t_cw  r_y    [0:STEPS-1];
    logic [31:0]   r_z    [0:STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phold <= (i_y == '0);
        if (i_x < 0) begin
            r_px <= -i_x;
            r_py <= -i_y;
            r_pz <= q2e_pkg::HALF_TURN;
        end else begin
            r_px <= i_x;
            r_py <= i_y;
            r_pz <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [31:0] ATAN = q2e_pkg::atan_step(k);
        logic          src_v, src_hold;
        q2e_pkg::t_cw  src_x, src_y, xs, ys;
        logic [31:0]   src_z;

        if (k == 0) begin : g_first
            assign src_v    = r_pv;
            assign src_hold = r_phold;
            assign src_x    = r_px;
            assign src_y    = r_py;
            assign src_z    = r_pz;
        end else begin : g_next
            assign src_v    = r_v[k-1];
            assign src_hold = r_hold[k-1];
            assign src_x    = r_x[k-1];
            assign src_y    = r_y[k-1];
            assign src_z    = r_z[k-1];
        end

        assign xs = src_x >>> k;
        assign ys = src_y >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_hold[k] <= src_hold;
            if (src_y > 0) begin
                r_x[k] <= src_x + ys;
                r_y[k] <= src_y - xs;
                r_z[k] <= src_hold ? src_z : src_z + ATAN;
            end else begin
                r_x[k] <= src_x - ys;
                r_y[k] <= src_y + xs;
                r_z[k] <= src_hold ? src_z : src_z - ATAN;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_angle = r_z[STEPS-1];

endmodule

// ===== hw/rtl/quaternion_to_euler.sv =====
// top level: unit quaternion to yaw, pitch and roll binary angles
// depends on q2e_pkg, q2e_front, q2e_isqrt, q2e_cordic
//
// channel   direction  handshake          fields
// request   in         i_start / o_busy   i_quat_w, i_quat_x, i_quat_y, i_quat_z
// result    out        o_done strobe      o_yaw_angle, o_pitch_angle, o_roll_angle,
//                                         o_pitch_clamped
//
// fully pipelined: one request per cycle, o_busy stays low
// pipeline: 4 front stages, 31 root stages, 29 cordic stages, 1 output stage
// the root pipeline for the pitch cosine sets the depth; yaw and roll wait in a delay line
// synchronous reset clears the valid bits only; results appear once each, no stalls

module quaternion_to_euler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  q2e_pkg::t_field           i_quat_w,
    input  q2e_pkg::t_field           i_quat_x,
    input  q2e_pkg::t_field           i_quat_y,
    input  q2e_pkg::t_field           i_quat_z,
    output logic                      o_done,
    output q2e_pkg::t_field           o_yaw_angle,
    output q2e_pkg::t_field           o_pitch_angle,
    output q2e_pkg::t_field           o_roll_angle,
    output logic                      o_pitch_clamped
);

    localparam int DL = q2e_pkg::SQRT_STEPS;
    localparam int PL = q2e_pkg::CORDIC_STEPS + 1;
    localparam logic [q2e_pkg::FIELD_W-1:0] QP_ANG = q2e_pkg::to_angle(q2e_pkg::QUARTER_POS);
    localparam logic [q2e_pkg::FIELD_W-1:0] QN_ANG = q2e_pkg::to_angle(q2e_pkg::QUARTER_NEG);

    q2e_pkg::t_side                  front_side;
    logic [q2e_pkg::N_W-1:0]         front_n;
    logic                            sq_valid;
    logic [q2e_pkg::ROOT_W-1:0]      sq_root;
    q2e_pkg::t_side                  r_dl [0:DL-1];
    q2e_pkg::t_pflag                 r_pf [0:PL-1];
    q2e_pkg::t_side                  dl_out;
    logic                            yaw_v, pitch_v, roll_v;
    logic [31:0]                     yaw_z, pitch_z, roll_z;
    logic [31:0]                     pitch_sel;

    assign o_busy = 1'b0;

    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_side  (front_side),
        .o_n     (front_n)
    );

    q2e_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_side.valid),
        .i_n     (front_n),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    for (genvar k = 0; k < DL; k++) begin : g_dl
        q2e_pkg::t_side src;
        if (k == 0) begin : g_first
            assign src = front_side;
        end else begin : g_next
            assign src = r_dl[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl[k].valid <= 1'b0;
            end else begin
                r_dl[k].valid <= src.valid;
            end
        end
        always_ff @(posedge i_clk) begin
            r_dl[k].clamp <= src.clamp;
            r_dl[k].sp    <= src.sp;
            r_dl[k].sy    <= src.sy;
            r_dl[k].cy    <= src.cy;
            r_dl[k].sr    <= src.sr;
            r_dl[k].cr    <= src.cr;
        end
    end

    assign dl_out = r_dl[DL-1];

    q2e_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dl_out.valid),
        .i_y     (q2e_pkg::t_cw'(dl_out.sy)),
        .i_x     (q2e_pkg::t_cw'(dl_out.cy)),
        .o_valid (yaw_v),
        .o_angle (yaw_z)
    );

    q2e_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_y     (q2e_pkg::t_cw'(dl_out.sp)),
        .i_x     ($signed(q2e_pkg::CW'(sq_root))),
        .o_valid (pitch_v),
        .o_angle (pitch_z)
    );

    q2e_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dl_out.valid),
        .i_y     (q2e_pkg::t_cw'(dl_out.sr)),
        .i_x     (q2e_pkg::t_cw'(dl_out.cr)),
        .o_valid (roll_v),
        .o_angle (roll_z)
    );

    for (genvar k = 0; k < PL; k++) begin : g_pf
        q2e_pkg::t_pflag src;
        if (k == 0) begin : g_first
            assign src.clamp = dl_out.clamp;
            assign src.neg   = dl_out.sp[q2e_pkg::SUM_W-1];
        end else begin : g_next
            assign src = r_pf[k-1];
        end
        always_ff @(posedge i_clk) begin
            r_pf[k] <= src;
        end
    end

    always_comb begin
        if (r_pf[PL-1].clamp) begin
            pitch_sel = r_pf[PL-1].neg ? q2e_pkg::QUARTER_NEG : q2e_pkg::QUARTER_POS;
        end else begin
            pitch_sel = pitch_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= yaw_v && pitch_v && roll_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_yaw_angle     <= q2e_pkg::to_angle(yaw_z);
        o_pitch_angle   <= q2e_pkg::to_angle(pitch_sel);
        o_roll_angle    <= q2e_pkg::to_angle(roll_z);
        o_pitch_clamped <= r_pf[PL-1].clamp;
    end

`ifndef SYNTHESIS
    a_clamp_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_pitch_clamped) |-> (o_pitch_angle == QP_ANG || o_pitch_angle == QN_ANG))
        else $error("clamped pitch is not a quarter turn");

    a_root_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dl_out.valid == sq_valid)
        else $error("root pipeline and delay line out of step");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (yaw_v == pitch_v) && (roll_v == pitch_v))
        else $error("cordic lanes out of step");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");
`endif

endmodule
